### hdl/ttf_pkg.sv
// package for the triangle tangent frame core
// holds widths, state codes and the shared-unit opcodes; no dependencies
package ttf_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W = 33;
    localparam int PROD_W = 67;
    localparam int OUT_W = 16;
    localparam int MAG_W = 30;
    localparam int DEF_COORD_FRAC_BITS = 16;
    localparam int DEF_OUT_FRAC_BITS = 14;
    localparam int S_TDATA_W = 160;
    localparam int M_TDATA_W = 96;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIFF,
        ST_DET,
        ST_CROSS,
        ST_VEC_LOAD,
        ST_SHIFT,
        ST_SQSUM,
        ST_SQRT,
        ST_DIV,
        ST_DIV_STORE,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        OP_SUB,
        OP_MULSUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t op;
        logic    start;
    } alu_ctrl_t;

endpackage

### hdl/ttf_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on ttf_pkg for the magnitude width
module ttf_div #(
    parameter int OUT_FRAC_BITS = ttf_pkg::DEF_OUT_FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [ttf_pkg::MAG_W+OUT_FRAC_BITS:0] num,
    input  logic [ttf_pkg::MAG_W:0]           den,
    output logic                              done,
    output logic [ttf_pkg::MAG_W+OUT_FRAC_BITS:0] quo
);
    localparam int NW = ttf_pkg::MAG_W + OUT_FRAC_BITS + 1;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [ttf_pkg::MAG_W:0] r_reg, r_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [ttf_pkg::MAG_W+1:0] trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
    end

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {r_reg, q_reg[NW-1]};
        if (start) begin
            q_next = num;
            r_next = '0;
            cnt_next = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den}) begin
                r_next = trial[ttf_pkg::MAG_W:0] - den;
                q_next = {q_reg[NW-2:0], 1'b1};
            end else begin
                r_next = trial[ttf_pkg::MAG_W:0];
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    assign done = busy_reg && (cnt_reg == CW'(1));
    assign quo = q_next;

endmodule

### hdl/triangle_tangent_frame_core.sv
// triangle tangent frame core: per-vertex frames from a de-indexed vertex stream
// depends on ttf_pkg and ttf_div; vertex 1 and 2 are held, vertex 3 starts the work
// (a zero determinant goes straight to output): one shared 33x33 multiply, one-bit
// shifts and a 32-step integer root per vector and six 45-step divides make up the
// work; then three result words leave one per taken beat
// reset (aresetn low, synchronous) clears the phase and the sequencer; held vertices not cleared
module triangle_tangent_frame_core #(
    parameter int OUT_FRAC_BITS = ttf_pkg::DEF_OUT_FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v
    input  logic [ttf_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z
    output logic [ttf_pkg::M_TDATA_W-1:0] m_tdata,
    // degenerate
    output logic                          m_tuser,
    output logic                          m_tlast
);
    localparam int PW = ttf_pkg::PROD_W;
    localparam int DW = ttf_pkg::DIFF_W;
    localparam int MW = ttf_pkg::MAG_W;
    localparam int NW = MW + OUT_FRAC_BITS + 1;
    localparam int CAP = (OUT_FRAC_BITS > 14) ? 32767 : (1 << OUT_FRAC_BITS);

    ttf_pkg::state_t st_reg, st_next;
    logic [1:0] phase_reg, phase_next;
    logic signed [31:0] hp_reg [6];
    logic signed [31:0] huv_reg [4];
    logic signed [DW-1:0] d_reg [10], d_next [10];  // e1 xyz, e2 xyz, du1 dv1, du2 dv2
    logic signed [PW-1:0] c_reg [7], c_next [7];   // det, t xyz, b xyz
    logic [3:0] idx_reg, idx_next;
    logic vec_reg, vec_next;
    logic [PW-1:0] m_reg [3], m_next [3];
    logic n_reg [3], n_next [3];
    logic [63:0] sum_reg, sum_next;
    logic [63:0] sq_x_reg, sq_x_next, sq_r_reg, sq_r_next, sq_b_reg, sq_b_next;
    logic [MW:0] len_reg, len_next;
    logic signed [ttf_pkg::OUT_W-1:0] o_reg [6], o_next [6];
    logic degen_reg, degen_next;
    logic [1:0] emit_reg, emit_next;
    logic div_start, div_done;
    logic [NW-1:0] div_num, div_quo;

    // shared multiplier operands
    logic signed [DW-1:0] ma, mb;
    logic signed [PW-1:0] prod;
    assign prod = PW'(ma) * PW'(mb);

    ttf_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(len_reg), .done(div_done), .quo(div_quo)
    );

    logic signed [31:0] in_f [5];
    always_comb begin
        for (int i = 0; i < 5; i++) in_f[i] = s_tdata[32*i +: 32];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ttf_pkg::ST_IDLE;
            phase_reg <= '0;
        end else begin
            st_reg <= st_next;
            phase_reg <= phase_next;
        end
        if (s_tvalid && s_tready && phase_reg != 2'd2) begin
            for (int i = 0; i < 3; i++) hp_reg[phase_reg[0]*3+i] <= in_f[i];
            huv_reg[phase_reg[0]*2] <= in_f[3];
            huv_reg[phase_reg[0]*2+1] <= in_f[4];
        end
        d_reg <= d_next; c_reg <= c_next; idx_reg <= idx_next; vec_reg <= vec_next;
        m_reg <= m_next; n_reg <= n_next; sum_reg <= sum_next;
        sq_x_reg <= sq_x_next; sq_r_reg <= sq_r_next; sq_b_reg <= sq_b_next;
        len_reg <= len_next; o_reg <= o_next; degen_reg <= degen_next;
        emit_reg <= emit_next;
    end

    logic [PW-1:0] mag_or;
    logic [63:0] sq_t;
    logic [NW-1:0] qcap;
    always_comb begin
        st_next = st_reg; phase_next = phase_reg;
        d_next = d_reg; c_next = c_reg; idx_next = idx_reg; vec_next = vec_reg;
        m_next = m_reg; n_next = n_reg; sum_next = sum_reg;
        sq_x_next = sq_x_reg; sq_r_next = sq_r_reg; sq_b_next = sq_b_reg;
        len_next = len_reg; o_next = o_reg; degen_next = degen_reg;
        emit_next = emit_reg;
        s_tready = 1'b0; div_start = 1'b0;
        ma = '0; mb = '0;
        mag_or = m_reg[0] | m_reg[1] | m_reg[2];
        sq_t = sq_r_reg + sq_b_reg;
        qcap = (div_quo > NW'(CAP)) ? NW'(CAP) : div_quo;
        unique case (st_reg)
            ttf_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (phase_reg == 2'd2) begin
                        phase_next = '0;
                        for (int i = 0; i < 3; i++) begin
                            d_next[i] = DW'(hp_reg[3+i]) - DW'(hp_reg[i]);
                            d_next[3+i] = DW'(in_f[i]) - DW'(hp_reg[i]);
                        end
                        d_next[6] = DW'(huv_reg[2]) - DW'(huv_reg[0]);
                        d_next[7] = DW'(huv_reg[3]) - DW'(huv_reg[1]);
                        d_next[8] = DW'(in_f[3]) - DW'(huv_reg[0]);
                        d_next[9] = DW'(in_f[4]) - DW'(huv_reg[1]);
                        st_next = ttf_pkg::ST_DIFF;
                    end else begin
                        phase_next = phase_reg + 2'd1;
                    end
                end
            end
            ttf_pkg::ST_DIFF: begin
                idx_next = '0;
                st_next = ttf_pkg::ST_DET;
            end
            ttf_pkg::ST_DET: begin
                // products in order: det a, det b, then per component t a,t b,b a,b b
                ma = d_reg[6]; mb = d_reg[9];
                c_next[0] = prod;
                st_next = ttf_pkg::ST_CROSS;
                idx_next = '0;
            end
            ttf_pkg::ST_CROSS: begin
                unique case (idx_reg)
                    4'd0: begin ma = d_reg[8]; mb = d_reg[7];
                        c_next[0] = c_reg[0] - prod; end
                    default: begin
                        case (idx_reg[1:0])
                            2'd1: begin ma = d_reg[9]; mb = d_reg[idx_reg[3:2]];
                                c_next[1+idx_reg[3:2]] = prod; end
                            2'd2: begin ma = d_reg[7]; mb = d_reg[3+idx_reg[3:2]];
                                c_next[1+idx_reg[3:2]] = c_reg[1+idx_reg[3:2]] - prod; end
                            2'd3: begin ma = d_reg[6]; mb = d_reg[3+idx_reg[3:2]];
                                c_next[4+idx_reg[3:2]] = prod; end
                            default: begin ma = d_reg[8]; mb = d_reg[idx_reg[3:2]-1];
                                c_next[3+idx_reg[3:2]] = c_reg[3+idx_reg[3:2]] - prod; end
                        endcase
                    end
                endcase
                idx_next = idx_reg + 4'd1;
                if (idx_reg == 4'd12) begin
                    vec_next = 1'b0;
                    degen_next = (c_reg[0] == '0);
                    st_next = ttf_pkg::ST_VEC_LOAD;
                end
            end
            ttf_pkg::ST_VEC_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    n_next[i] = c_reg[(vec_reg ? 4 : 1)+i][PW-1];
                    m_next[i] = n_next[i] ? PW'(-c_reg[(vec_reg ? 4 : 1)+i])
                                          : c_reg[(vec_reg ? 4 : 1)+i];
                end
                st_next = degen_reg ? ttf_pkg::ST_EMIT : ttf_pkg::ST_SHIFT;
                emit_next = '0;
            end
            ttf_pkg::ST_SHIFT: begin
                if (mag_or == '0) begin
                    degen_next = 1'b1;
                    emit_next = '0;
                    st_next = ttf_pkg::ST_EMIT;
                end else if (mag_or[PW-1:MW] != '0) begin
                    for (int i = 0; i < 3; i++) m_next[i] = m_reg[i] >> 1;
                end else begin
                    idx_next = '0; sum_next = '0;
                    st_next = ttf_pkg::ST_SQSUM;
                end
            end
            ttf_pkg::ST_SQSUM: begin
                ma = DW'(m_reg[idx_reg[1:0]][MW-1:0]);
                mb = ma;
                sum_next = sum_reg + prod[63:0];
                idx_next = idx_reg + 4'd1;
                if (idx_reg == 4'd2) begin
                    sq_x_next = sum_next; sq_r_next = '0;
                    sq_b_next = 64'h4000_0000_0000_0000;
                    st_next = ttf_pkg::ST_SQRT;
                end
            end
            ttf_pkg::ST_SQRT: begin
                if (sq_x_reg >= sq_t) begin
                    sq_x_next = sq_x_reg - sq_t;
                    sq_r_next = (sq_r_reg >> 1) + sq_b_reg;
                end else begin
                    sq_r_next = sq_r_reg >> 1;
                end
                sq_b_next = sq_b_reg >> 2;
                if (sq_b_reg == 64'd1) begin
                    len_next = (MW+1)'(sq_r_next);
                    idx_next = '0;
                    div_start = 1'b1;
                    st_next = ttf_pkg::ST_DIV;
                end
            end
            ttf_pkg::ST_DIV: begin
                if (div_done) begin
                    o_next[{vec_reg, 2'b00} - {2'b0, vec_reg} + idx_reg[1:0]] =
                        n_reg[idx_reg[1:0]] ? -ttf_pkg::OUT_W'(qcap) : ttf_pkg::OUT_W'(qcap);
                    st_next = ttf_pkg::ST_DIV_STORE;
                end
            end
            ttf_pkg::ST_DIV_STORE: begin
                if (idx_reg == 4'd2) begin
                    if (vec_reg) begin
                        emit_next = '0;
                        st_next = ttf_pkg::ST_EMIT;
                    end else begin
                        vec_next = 1'b1;
                        st_next = ttf_pkg::ST_VEC_LOAD;
                    end
                end else begin
                    idx_next = idx_reg + 4'd1;
                    div_start = 1'b1;
                    st_next = ttf_pkg::ST_DIV;
                end
            end
            ttf_pkg::ST_EMIT: begin
                if (m_tready) begin
                    emit_next = emit_reg + 2'd1;
                    if (emit_reg == 2'd2) st_next = ttf_pkg::ST_IDLE;
                end
            end
            default: st_next = ttf_pkg::ST_IDLE;
        endcase
        // dividend for the component and length the divider picks up at start
        div_num = NW'({m_reg[idx_next[1:0]][MW-1:0], {OUT_FRAC_BITS{1'b0}}})
                  + NW'(len_next >> 1);
    end

    // det sign and degenerate applied at the output
    logic signed [ttf_pkg::OUT_W-1:0] ov [6];
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            ov[i] = degen_reg ? '0 : (c_reg[0][PW-1] ? -o_reg[i] : o_reg[i]);
            m_tdata[16*i +: 16] = ov[i];
        end
    end
    assign m_tvalid = (st_reg == ttf_pkg::ST_EMIT);
    assign m_tuser = degen_reg;
    assign m_tlast = (emit_reg == 2'd2);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input and output both open");
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> st_reg == ttf_pkg::ST_IDLE)
        else $error("emit did not end");
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0) else $error("degenerate not zero");

endmodule
